>>> rtl/rdq_pkg.sv
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared types and constants of the reversible deque.
// ----------------------------------------------------------------------------
`default_nettype none

package rdq_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned WORD_W   = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_REVERSE    = 3'd4
  } req_e_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e_t;

endpackage

`default_nettype wire

>>> rtl/rdq_req_if.sv
// ----------------------------------------------------------------------------
// rdq_req_if
// Request channel: request code and word to push.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdq_req_if
  import rdq_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

`default_nettype wire

>>> rtl/rdq_rsp_if.sv
// ----------------------------------------------------------------------------
// rdq_rsp_if
// Response channel: status and popped word.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdq_rsp_if
  import rdq_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [WORD_W-1:0] pop_value;

  modport source (output valid, output status, output pop_value, input ready);
  modport sink   (input valid, input status, input pop_value, output ready);
endinterface

`default_nettype wire

>>> rtl/reversible_deque_core.sv
// ----------------------------------------------------------------------------
// reversible_deque_core
// Double-ended queue of signed words in a ring memory with reverse flag.
// ----------------------------------------------------------------------------
// Words live in a single-port-write, registered-read memory of DEPTH entries
// addressed as a ring from a head pointer, with an occupancy count and a
// reverse flag that swaps the roles of the two ends. Pushes, reverse toggles,
// unused codes and pops that find the queue empty finish in the idle state;
// a pop that returns a word reads the memory into its read register, then
// the read state loads the response register. A push into a full queue and
// a pop from an empty one each give one response; successful pushes and toggles
// give none. A request is taken in the idle state when the response register is
// free or being emptied in the same cycle. No clearing pass is needed after reset.
`default_nettype none

module reversible_deque_core
  import rdq_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  wire        clk,
  input  wire        rst_n,
  rdq_req_if.sink    in_req,
  rdq_rsp_if.source  out_rsp
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WORD_W-1:0] mem [DEPTH];

  state_e_t            state_r, state_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       occ_r, occ_nxt;
  logic                swap_r, swap_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [WORD_W-1:0]   out_value_r, out_value_nxt;
  logic [WORD_W-1:0]   rd_data_r;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          accept, out_free, full, empty;
  logic [AW-1:0] head_dec, head_inc, tail_idx, back_idx;
  logic [CW:0]   tail_sum, back_sum;
  req_e_t        req;

  assign out_free = !out_valid_r || out_rsp.ready;
  assign in_req.ready = (state_r == S_IDLE) && out_free;
  assign accept = in_req.valid && in_req.ready;
  assign full  = (occ_r == CW'(DEPTH));
  assign empty = (occ_r == '0);

  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign tail_sum = (CW+1)'(head_r) + (CW+1)'(occ_r);
  assign back_sum = (CW+1)'(head_r) + (CW+1)'(occ_r - CW'(1));
  assign tail_idx = (tail_sum >= (CW+1)'(DEPTH)) ? AW'(tail_sum - (CW+1)'(DEPTH))
                                                 : AW'(tail_sum);
  assign back_idx = (back_sum >= (CW+1)'(DEPTH)) ? AW'(back_sum - (CW+1)'(DEPTH))
                                                 : AW'(back_sum);

  // reverse flag swaps front and back
  always_comb begin
    req = req_e_t'(in_req.req_type);
    if (swap_r) begin
      case (req_e_t'(in_req.req_type))
        REQ_PUSH_FRONT: req = REQ_PUSH_BACK;
        REQ_PUSH_BACK:  req = REQ_PUSH_FRONT;
        REQ_POP_BACK:   req = REQ_POP_FRONT;
        REQ_POP_FRONT:  req = REQ_POP_BACK;
        default:        req = req_e_t'(in_req.req_type);
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    occ_nxt        = occ_r;
    swap_nxt       = swap_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    wr_addr        = tail_idx;
    rd_addr        = head_r;

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (req)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              if (full) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_FULL;
                out_value_nxt  = '0;
              end else begin
                wr_en   = 1'b1;
                occ_nxt = occ_r + CW'(1);
                if (req == REQ_PUSH_FRONT) begin
                  wr_addr  = head_dec;
                  head_nxt = head_dec;
                end
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_EMPTY;
                out_value_nxt  = '0;
              end else begin
                rd_en     = 1'b1;
                occ_nxt   = occ_r - CW'(1);
                state_nxt = S_READ;
                if (req == REQ_POP_FRONT) begin
                  head_nxt = head_inc;
                end else begin
                  rd_addr = back_idx;
                end
              end
            end
            REQ_REVERSE: begin
              swap_nxt = !swap_r;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_OK;
        out_value_nxt  = rd_data_r;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      occ_r       <= '0;
      swap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      swap_r      <= swap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_req.push_value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.status    = out_status_r;
  assign out_rsp.pop_value = out_value_r;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("occupancy above depth");

  a_read_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> !out_valid_r)
    else $error("response register busy during pop read");

  a_ok_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && out_status_r == STAT_OK |-> $past(state_r == S_READ))
    else $error("word response without memory read");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && $past(rst_n) && $past(rd_en) |-> 1'b0)
    else $error("pop read not followed by read state");
`endif

endmodule

`default_nettype wire
